[sv/rfc_pkg.sv]
// Shared types and constants for the reply frame checker.
// Holds the word layouts, the frame layout positions and the verdict codes.
// No dependencies.
package rfc_pkg;

	// Input word codes.
	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// Result word kinds.
	localparam logic KIND_CONTENT = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// Verdict codes.
	localparam logic [2:0] VERDICT_OK        = 3'd0;
	localparam logic [2:0] VERDICT_BAD_START = 3'd1;
	localparam logic [2:0] VERDICT_BAD_ADDR  = 3'd2;
	localparam logic [2:0] VERDICT_BAD_LEN   = 3'd3;
	localparam logic [2:0] VERDICT_BAD_SUM   = 3'd4;

	// Start code bytes.
	localparam logic [7:0] START_HI = 8'hEF;
	localparam logic [7:0] START_LO = 8'h01;

	// Byte positions of the frame header.
	localparam logic [3:0] POS_START_HI   = 4'd0;
	localparam logic [3:0] POS_START_LO   = 4'd1;
	localparam logic [3:0] POS_ADDR_LAST  = 4'd5;
	localparam logic [3:0] POS_PACKET_ID  = 4'd6;
	localparam logic [3:0] POS_LEN_HI     = 4'd7;
	localparam logic [3:0] POS_LEN_LO     = 4'd8;
	localparam logic [3:0] HEADER_BYTES   = 4'd9;
	localparam logic [3:0] TRAILER_BYTES  = 4'd2;

	localparam logic [15:0] MIN_LENGTH = 16'd3;

	typedef struct packed {
		logic       operation;
		logic [7:0] data_byte;
	} in_word_t;

	typedef struct packed {
		logic       kind;
		logic [6:0] content_offset;
		logic [7:0] content_byte;
		logic [2:0] verdict;
		logic [7:0] confirm_code;
	} out_word_t;

	// Contents of the input register.
	typedef struct packed {
		logic     valid;
		in_word_t word;
	} stage_t;

	// Result that one input word produces.
	typedef struct packed {
		logic      valid;
		out_word_t word;
	} result_t;

endpackage

[sv/rfc_in_stage.sv]
// Input register of the reply frame checker.
// Takes one word from the input channel and holds it until the parser uses it.
// Depends on rfc_pkg.
module rfc_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  rfc_pkg::in_word_t in_data,
	input  logic              take,
	output rfc_pkg::stage_t   stage
);

	logic              valid_s1;
	rfc_pkg::in_word_t word_s1;

	// The register can load when it is empty or its word leaves this cycle.
	assign in_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			word_s1 <= in_data;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.word  = word_s1;

endmodule

[sv/rfc_parser.sv]
// Frame parser of the reply frame checker.
// Keeps the frame state and works out the result of one input word.
// Depends on rfc_pkg.
module rfc_parser #(
	parameter int MAX_FRAME_BYTES = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  rfc_pkg::in_word_t word,
	input  logic [31:0]       module_address,
	output rfc_pkg::result_t  result
);

	localparam int PW = $clog2(MAX_FRAME_BYTES);

	logic [PW-1:0] byte_position_q;
	logic [15:0]   frame_length_q;
	logic [15:0]   running_sum_q;
	logic [7:0]    checksum_high_q;
	logic [7:0]    first_content_q;
	logic          frame_finished_q;

	logic [PW-1:0] byte_position_d;
	logic [15:0]   frame_length_d;
	logic [15:0]   running_sum_d;
	logic [7:0]    checksum_high_d;
	logic [7:0]    first_content_d;
	logic          frame_finished_d;

	logic [7:0]  b;
	logic [7:0]  want_addr;
	logic [15:0] full_length;
	logic [16:0] length_end;
	logic [16:0] last_content_end;
	logic [16:0] pos_wide;
	logic [15:0] sum_plus_b;

	assign b           = word.data_byte;
	assign full_length = {frame_length_q[15:8], b};
	assign length_end  = 17'(full_length) + 17'(rfc_pkg::HEADER_BYTES);
	assign pos_wide    = 17'(byte_position_q);
	assign sum_plus_b  = running_sum_q + 16'(b);
	// Position of the high checksum byte.
	assign last_content_end = 17'(frame_length_q) + 17'(rfc_pkg::HEADER_BYTES)
		- 17'(rfc_pkg::TRAILER_BYTES);

	// Address bytes come at positions two through five, most significant first.
	always_comb begin
		case (byte_position_q[1:0])
			2'b10:   want_addr = module_address[31:24];
			2'b11:   want_addr = module_address[23:16];
			2'b00:   want_addr = module_address[15:8];
			2'b01:   want_addr = module_address[7:0];
			default: want_addr = module_address[7:0];
		endcase
	end

	always_comb begin
		byte_position_d  = byte_position_q;
		frame_length_d   = frame_length_q;
		running_sum_d    = running_sum_q;
		checksum_high_d  = checksum_high_q;
		first_content_d  = first_content_q;
		frame_finished_d = frame_finished_q;
		result           = '0;

		if (word.operation == rfc_pkg::OP_RESTART) begin
			byte_position_d  = '0;
			frame_length_d   = '0;
			running_sum_d    = '0;
			checksum_high_d  = '0;
			first_content_d  = '0;
			frame_finished_d = 1'b0;
		end else if (!frame_finished_q) begin
			byte_position_d = byte_position_q + 1'b1;
			result.word.kind = rfc_pkg::KIND_VERDICT;

			if (byte_position_q == PW'(rfc_pkg::POS_START_HI)) begin
				if (b != rfc_pkg::START_HI) begin
					result.valid        = 1'b1;
					result.word.verdict = rfc_pkg::VERDICT_BAD_START;
				end
			end else if (byte_position_q == PW'(rfc_pkg::POS_START_LO)) begin
				if (b != rfc_pkg::START_LO) begin
					result.valid        = 1'b1;
					result.word.verdict = rfc_pkg::VERDICT_BAD_START;
				end
			end else if (byte_position_q <= PW'(rfc_pkg::POS_ADDR_LAST)) begin
				if (b != want_addr) begin
					result.valid        = 1'b1;
					result.word.verdict = rfc_pkg::VERDICT_BAD_ADDR;
				end
			end else if (byte_position_q <= PW'(rfc_pkg::POS_LEN_LO)) begin
				// Packet id and length bytes count toward the checksum.
				running_sum_d = sum_plus_b;
				if (byte_position_q == PW'(rfc_pkg::POS_LEN_HI)) begin
					frame_length_d = {b, 8'h00};
				end else if (byte_position_q == PW'(rfc_pkg::POS_LEN_LO)) begin
					frame_length_d = full_length;
					if (full_length < rfc_pkg::MIN_LENGTH ||
						length_end > 17'(MAX_FRAME_BYTES)) begin
						result.valid        = 1'b1;
						result.word.verdict = rfc_pkg::VERDICT_BAD_LEN;
					end
				end
			end else if (pos_wide < last_content_end) begin
				running_sum_d = sum_plus_b;
				if (byte_position_q == PW'(rfc_pkg::HEADER_BYTES)) begin
					first_content_d = b;
				end
				result.valid               = 1'b1;
				result.word.kind           = rfc_pkg::KIND_CONTENT;
				result.word.content_offset =
					7'(byte_position_q - PW'(rfc_pkg::HEADER_BYTES));
				result.word.content_byte   = b;
			end else if (pos_wide == last_content_end) begin
				checksum_high_d = b;
			end else begin
				result.valid = 1'b1;
				if ({checksum_high_q, b} == running_sum_q) begin
					result.word.verdict      = rfc_pkg::VERDICT_OK;
					result.word.confirm_code = first_content_q;
				end else begin
					result.word.verdict = rfc_pkg::VERDICT_BAD_SUM;
				end
			end

			if (result.valid && result.word.kind == rfc_pkg::KIND_VERDICT) begin
				frame_finished_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q  <= '0;
			frame_length_q   <= '0;
			running_sum_q    <= '0;
			checksum_high_q  <= '0;
			first_content_q  <= '0;
			frame_finished_q <= 1'b0;
		end else if (fire) begin
			byte_position_q  <= byte_position_d;
			frame_length_q   <= frame_length_d;
			running_sum_q    <= running_sum_d;
			checksum_high_q  <= checksum_high_d;
			first_content_q  <= first_content_d;
			frame_finished_q <= frame_finished_d;
		end
	end

endmodule

[sv/sensor_module_reply_frame_checker_core.sv]
// Reply frame checker: one received serial byte per word in, at most one
// content or verdict word out per byte. Depends on rfc_pkg, rfc_in_stage and
// rfc_parser.
//
// The block takes one byte every clock cycle unless the input side stalls.
// Each word passes through an input register, the frame parser logic and a
// result register. A result word is loaded into the result register when the
// parser takes its byte from the input register, and the parser waits while the
// result register holds a word that the receiver is stalling. A frame
// is the start code EF 01, four address bytes compared against module_address
// (first byte most significant), a packet id, a 16-bit length, length minus two
// content bytes and a 16-bit checksum; the checksum is the wrapping 16-bit sum
// from the packet id through the last content byte. Every content byte is passed
// out with its offset, and a single verdict word closes the frame at the
// first error or at the low checksum byte; an ok verdict carries the first
// content byte as its confirm code. A length below three, or one whose frame
// would exceed MAX_FRAME_BYTES, is reported as a bad length. After the verdict
// bytes are dropped until a restart word arrives; a frame that stops early
// gives no verdict, so the host is expected to time out. The address register
// should be written only while no frame is in flight; a write does not restart
// the frame in progress. The input side keeps accepting while a result waits,
// and stalls only when the input register holds a word and the result register
// holds one that the receiver is stalling.
module sensor_module_reply_frame_checker_core #(
	parameter int MAX_FRAME_BYTES = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  rfc_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output rfc_pkg::out_word_t out_data,
	input  logic               cfg_write_en,
	input  logic [31:0]        cfg_write_data
);

	logic [31:0]        module_address_q;
	logic               out_valid_q;
	rfc_pkg::out_word_t out_word_q;

	rfc_pkg::stage_t  stage;
	rfc_pkg::result_t result;
	logic             out_free;
	logic             fire;

	// The result register can load when empty or being drained this cycle.
	assign out_free = !out_valid_q || !out_stall;
	assign fire     = stage.valid && out_free;

	rfc_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.take     (out_free),
		.stage    (stage)
	);

	rfc_parser #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.word           (stage.word),
		.module_address (module_address_q),
		.result         (result)
	);

	// Address register; resets to all ones.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			module_address_q <= '1;
		end else if (cfg_write_en) begin
			module_address_q <= cfg_write_data;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire && result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && result.valid) begin
			out_word_q <= result.word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_word_q;

endmodule

[test/rfc_reply_checker.sv]
`timescale 1ns / 1ps
// Result checker for the reply frame checker: watches the word channels and the address port.
// It predicts every result word and compares it with what the block delivers.
// Depends on rfc_pkg.
module rfc_reply_checker #(
	parameter int MAX_FRAME_BYTES = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  rfc_pkg::in_word_t  in_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  rfc_pkg::out_word_t out_data,
	input  logic               cfg_write_en,
	input  logic [31:0]        cfg_write_data,
	output int                 outstanding,
	output int                 fail_count
);
	import rfc_pkg::*;

	logic [31:0] address_reg;
	int unsigned bytes_taken;
	logic [15:0] declared_len;
	logic [15:0] byte_sum;
	logic [7:0]  sum_hi_byte;
	logic [7:0]  confirm_byte;
	bit          verdict_given;

	out_word_t expected_replies[$];

	function automatic void clear_frame();
		bytes_taken   = 0;
		declared_len  = '0;
		byte_sum      = '0;
		sum_hi_byte   = '0;
		confirm_byte  = '0;
		verdict_given = 1'b0;
	endfunction

	function automatic bit close_frame(input logic [2:0] code, input logic [7:0] confirm,
			output out_word_t r);
		r = '0;
		r.kind = KIND_VERDICT;
		r.verdict = code;
		r.confirm_code = confirm;
		verdict_given = 1'b1;
		return 1'b1;
	endfunction

	// Returns 1 and fills r when the word produces a result word.
	function automatic bit predict_reply(input in_word_t w, output out_word_t r);
		int unsigned pos;
		logic [7:0]  b;
		logic [7:0]  want;
		b = w.data_byte;
		r = '0;
		if (w.operation == OP_RESTART) begin
			clear_frame();
			return 1'b0;
		end
		if (verdict_given)
			return 1'b0;
		pos = bytes_taken;
		bytes_taken = pos + 1;
		if (pos <= 1) begin
			want = (pos == 0) ? START_HI : START_LO;
			if (b != want)
				return close_frame(VERDICT_BAD_START, 8'h00, r);
			return 1'b0;
		end
		if (pos <= 5) begin
			want = 8'(address_reg >> (8 * (5 - pos)));
			if (b != want)
				return close_frame(VERDICT_BAD_ADDR, 8'h00, r);
			return 1'b0;
		end
		if (pos <= 8) begin
			byte_sum = byte_sum + b;
			if (pos == 7) begin
				declared_len = {b, 8'h00};
			end else if (pos == 8) begin
				declared_len[7:0] = b;
				if (declared_len < 16'd3 || 9 + int'(declared_len) > MAX_FRAME_BYTES)
					return close_frame(VERDICT_BAD_LEN, 8'h00, r);
			end
			return 1'b0;
		end
		// The length is known to be sane from here on.
		if (pos < 9 + declared_len - 2) begin
			byte_sum = byte_sum + b;
			if (pos == 9)
				confirm_byte = b;
			r.kind = KIND_CONTENT;
			r.content_offset = 7'(pos - 9);
			r.content_byte = b;
			return 1'b1;
		end
		if (pos == 9 + declared_len - 2) begin
			sum_hi_byte = b;
			return 1'b0;
		end
		if ({sum_hi_byte, b} == byte_sum)
			return close_frame(VERDICT_OK, confirm_byte, r);
		return close_frame(VERDICT_BAD_SUM, 8'h00, r);
	endfunction

	function automatic string describe(input out_word_t r);
		return $sformatf("kind=%0d offset=%0d byte=%02h verdict=%0d confirm=%02h",
			r.kind, r.content_offset, r.content_byte, r.verdict, r.confirm_code);
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t got;
		out_word_t want;
		if (!arst_n) begin
			address_reg = 32'hFFFF_FFFF;
			clear_frame();
			expected_replies.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (cfg_write_en)
				address_reg = cfg_write_data;
			if (out_valid && !out_stall) begin
				got = out_data;
				if (expected_replies.size() == 0) begin
					note_failure($sformatf("result word with none expected: %s", describe(got)));
				end else begin
					want = expected_replies.pop_front();
					if (got.kind !== want.kind || got.content_offset !== want.content_offset ||
							got.content_byte !== want.content_byte ||
							got.verdict !== want.verdict || got.confirm_code !== want.confirm_code)
						note_failure($sformatf("result mismatch: expected %s, got %s",
							describe(want), describe(got)));
				end
			end
			if (in_valid && !in_stall) begin
				if (predict_reply(in_data, want))
					expected_replies.push_back(want);
			end
			outstanding <= expected_replies.size();
		end
	end

endmodule

[test/sensor_module_reply_frame_checker_core_test.sv]
`timescale 1ns / 1ps
// Top of the reply frame checker testbench: clock, reset, frame stimulus and the verdict.
// Depends on rfc_pkg, sensor_module_reply_frame_checker_core and rfc_reply_checker.
module sensor_module_reply_frame_checker_core_test;
	import rfc_pkg::*;

	localparam int FRAME_LIMIT = 128;
	// Longest length field that still fits the frame buffer with its nine header bytes.
	localparam int MAX_LEN = FRAME_LIMIT - 9;
	localparam int PHASES = 5;
	localparam int PHASE_WORDS = 400;

	// Kinds of frame the random part sends. Most are well formed so that the
	// content and checksum stages see plenty of traffic.
	typedef enum int {
		FRAME_GOOD,
		FRAME_BAD_START,
		FRAME_BAD_ADDR,
		FRAME_SHORT_LEN,
		FRAME_LONG_LEN,
		FRAME_BAD_SUM,
		FRAME_CUT_SHORT,
		FRAME_NOISE
	} frame_flavor_e;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	in_word_t    in_data = '0;
	logic        out_stall = 1'b0;
	logic        cfg_write_en = 1'b0;
	logic [31:0] cfg_write_data = '0;
	logic        in_stall;
	logic        out_valid;
	out_word_t   out_data;
	int          outstanding;
	int          fail_count;

	// The address the block holds, used to build frames that get past the address check.
	logic [31:0] current_address = 32'hFFFF_FFFF;
	logic [7:0]  frame_bytes[$];
	bit          steady_input;
	int          words_sent;

	sensor_module_reply_frame_checker_core #(
		.MAX_FRAME_BYTES(FRAME_LIMIT)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_data      (out_data),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data)
	);

	rfc_reply_checker #(
		.MAX_FRAME_BYTES(FRAME_LIMIT)
	) reply_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_data      (out_data),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.outstanding   (outstanding),
		.fail_count    (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Gap before the next input word: usually none, sometimes a short one and
	// now and then a long pause. Steady frames run without any gap.
	function automatic int pick_gap();
		int roll;
		if (steady_input)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offers one word and returns at the edge where it is taken. When the next
	// word follows without a gap, valid simply stays high.
	task automatic send_word(input logic op, input logic [7:0] value);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= {op, value};
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	task automatic send_bytes();
		foreach (frame_bytes[i])
			send_word(OP_BYTE, frame_bytes[i]);
	endtask

	// Waits until every predicted result word has come out, then lets the
	// two-stage pipeline empty of words that produce nothing.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_address(input logic [31:0] value);
		settle();
		cfg_write_en <= 1'b1;
		cfg_write_data <= value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		current_address = value;
	endtask

	// Most lengths are short to keep frames quick; the full buffer and the
	// smallest legal length still show up regularly.
	function automatic logic [15:0] pick_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 75)
			return 16'($urandom_range(3, 20));
		if (roll < 90)
			return 16'($urandom_range(21, MAX_LEN));
		return (roll < 95) ? 16'd3 : 16'(MAX_LEN);
	endfunction

	function automatic logic [15:0] pick_oversize();
		case ($urandom_range(0, 2))
			0: return 16'(MAX_LEN + 1);
			1: return 16'hFFFF;
			default: return 16'($urandom_range(MAX_LEN + 2, 65535));
		endcase
	endfunction

	// Builds the bytes of one frame into frame_bytes. A well-formed frame is
	// built first and then damaged the way the flavor asks.
	task automatic build_frame(input frame_flavor_e flavor);
		logic [15:0] len;
		logic [15:0] sum;
		logic [7:0]  pid;
		logic [7:0]  b;
		int          spot;
		int          cut;
		frame_bytes.delete();
		if (flavor == FRAME_SHORT_LEN)
			len = 16'($urandom_range(0, 2));
		else if (flavor == FRAME_LONG_LEN)
			len = pick_oversize();
		else
			len = pick_length();
		pid = 8'($urandom);
		frame_bytes.push_back(START_HI);
		frame_bytes.push_back(START_LO);
		for (int k = 3; k >= 0; k--)
			frame_bytes.push_back(current_address[8 * k +: 8]);
		frame_bytes.push_back(pid);
		frame_bytes.push_back(len[15:8]);
		frame_bytes.push_back(len[7:0]);
		sum = pid + len[15:8] + len[7:0];
		if (len >= 16'd3 && int'(len) <= MAX_LEN) begin
			for (int i = 0; i < int'(len) - 2; i++) begin
				b = 8'($urandom);
				frame_bytes.push_back(b);
				sum = sum + b;
			end
			frame_bytes.push_back(sum[15:8]);
			frame_bytes.push_back(sum[7:0]);
		end
		case (flavor)
			FRAME_BAD_START: begin
				spot = $urandom_range(0, 1);
				frame_bytes[spot] ^= 8'($urandom_range(1, 255));
			end
			FRAME_BAD_ADDR: begin
				spot = $urandom_range(2, 5);
				frame_bytes[spot] ^= 8'($urandom_range(1, 255));
			end
			FRAME_BAD_SUM: begin
				spot = frame_bytes.size() - 1 - $urandom_range(0, 1);
				frame_bytes[spot] ^= 8'($urandom_range(1, 255));
			end
			FRAME_CUT_SHORT: begin
				// The frame stops early; the next restart abandons it.
				cut = $urandom_range(1, frame_bytes.size() - 1);
				repeat (cut) void'(frame_bytes.pop_back());
			end
			FRAME_NOISE: begin
				frame_bytes.delete();
				repeat ($urandom_range(1, 12))
					frame_bytes.push_back(8'($urandom));
			end
			default: ;
		endcase
		// Stray bytes after the verdict must be dropped by the block.
		if (flavor != FRAME_CUT_SHORT && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3))
				frame_bytes.push_back(8'($urandom));
	endtask

	function automatic frame_flavor_e pick_flavor();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return FRAME_GOOD;
		if (roll < 61) return FRAME_BAD_START;
		if (roll < 68) return FRAME_BAD_ADDR;
		if (roll < 74) return FRAME_SHORT_LEN;
		if (roll < 80) return FRAME_LONG_LEN;
		if (roll < 88) return FRAME_BAD_SUM;
		if (roll < 95) return FRAME_CUT_SHORT;
		return FRAME_NOISE;
	endfunction

	// The receiver stalls in bursts: mostly short ones, a few long ones, and
	// free-running stretches in between.
	initial begin
		int run;
		int hold;
		@(posedge arst_n);
		forever begin
			run = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
			repeat (run) @(posedge clk);
			hold = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
			out_stall <= 1'b1;
			repeat (hold) @(posedge clk);
			out_stall <= 1'b0;
		end
	end

	initial begin
		logic [31:0] phase_address;
		steady_input = 1'b0;
		words_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A wrong first start byte, then a byte after the verdict that must be ignored.
		send_word(OP_RESTART, 8'h00);
		send_word(OP_BYTE, 8'h00);
		send_word(OP_BYTE, START_HI);
		// A wrong second start byte.
		send_word(OP_RESTART, 8'hFF);
		send_word(OP_BYTE, START_HI);
		send_word(OP_BYTE, 8'h00);
		// Under the reset address, the last address byte is off by one.
		send_word(OP_RESTART, 8'h00);
		send_word(OP_BYTE, START_HI);
		send_word(OP_BYTE, START_LO);
		repeat (3) send_word(OP_BYTE, 8'hFF);
		send_word(OP_BYTE, 8'hFE);
		// The smallest legal frame, with the address changed after the start code.
		// The write must not restart the frame, and the new address applies at once.
		send_word(OP_RESTART, 8'h00);
		send_word(OP_BYTE, START_HI);
		send_word(OP_BYTE, START_LO);
		write_address(32'h0000_0000);
		repeat (4) send_word(OP_BYTE, 8'h00);
		send_word(OP_BYTE, 8'hFF);
		send_word(OP_BYTE, 8'h00);
		send_word(OP_BYTE, 8'h03);
		send_word(OP_BYTE, 8'h80);
		send_word(OP_BYTE, 8'h01);
		send_word(OP_BYTE, 8'h82);

		// Random frames in several address phases, the all-zero and all-one
		// addresses among them.
		words_sent = 0;
		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				phase_address = (p == 2) ? 32'hFFFF_FFFF : 32'($urandom);
				write_address(phase_address);
			end
			while (words_sent < (p + 1) * PHASE_WORDS) begin
				steady_input = ($urandom_range(0, 3) == 0);
				build_frame(pick_flavor());
				// Now and then the restart is left out, so the bytes land on a
				// finished or an abandoned frame.
				if ($urandom_range(0, 19) != 0)
					send_word(OP_RESTART, 8'($urandom));
				send_bytes();
			end
		end

		settle();
		if (fail_count == 0)
			$display("sensor_module_reply_frame_checker_core regression: pass");
		else
			$display("sensor_module_reply_frame_checker_core regression: fail");
		$finish;
	end

	// A run that hangs on a handshake or a missing result ends here.
	initial begin
		#4_000_000;
		$display("sensor_module_reply_frame_checker_core regression: fail");
		$finish;
	end

endmodule
